FILE: hdl/multi_slot_soft_timer_bank_unit_defines.svh
// Assertion macros used by the timer bank top level.
`ifndef MULTI_SLOT_SOFT_TIMER_BANK_UNIT_DEFINES_SVH
`define MULTI_SLOT_SOFT_TIMER_BANK_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MSSTB_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MSSTB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/msstb_pkg.sv
// Types, codes and constants of the timer slot bank.
package msstb_pkg;

    localparam int NUM_SLOTS = 32;
    localparam int SLOT_W    = 5;
    localparam int CNT_W     = 32;
    localparam int TOTAL_W   = 6;
    localparam int CMD_W     = 3;
    localparam int S_DATA_W  = 80;
    localparam int M_DATA_W  = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK       = 3'd0,
        CMD_APPEND     = 3'd1,
        CMD_RELEASE    = 3'd2,
        CMD_SET_ACTIVE = 3'd3,
        CMD_SET_VALUE  = 3'd4
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    // One slot as held in a cell of the ring.
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] limit;
        logic             up;
        logic             shot;
        logic             run;
        logic             free;
    } slot_rec_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  count_value;
        logic [CNT_W-1:0]  limit_value;
        logic              count_up;
        logic              one_shot;
        logic              active;
    } item_t;

    // Status of the slot passing the head unit.
    typedef struct packed {
        logic hit;
        logic claim;
        logic run_inc;
        logic run_dec;
    } head_stat_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] active_count;
        logic [CNT_W-1:0]   expired_mask;
        logic               no_free_slot;
        logic [SLOT_W-1:0]  slot_granted;
    } result_t;

endpackage

FILE: hdl/msstb_cell.sv
// One ring cell: holds a single timer slot and passes it on when the ring moves.
module msstb_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                shift_en,
    input  msstb_pkg::slot_rec_t rec_in,
    output msstb_pkg::slot_rec_t rec_out
);
    import msstb_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] limit_reg;
    logic             up_reg;
    logic             shot_reg;
    logic             run_reg;
    logic             free_reg;

    // flags come out of reset as a free, idle slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_reg   <= 1'b0;
            shot_reg <= 1'b0;
            run_reg  <= 1'b0;
            free_reg <= 1'b1;
        end else if (shift_en) begin
            up_reg   <= rec_in.up;
            shot_reg <= rec_in.shot;
            run_reg  <= rec_in.run;
            free_reg <= rec_in.free;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            count_reg <= rec_in.count;
            limit_reg <= rec_in.limit;
        end
    end

    assign rec_out = {count_reg, limit_reg, up_reg, shot_reg, run_reg, free_reg};

endmodule

FILE: hdl/msstb_head.sv
// Head unit: applies the current command to the slot leaving the ring.
module msstb_head (
    input  msstb_pkg::slot_rec_t  rec_in,
    input  msstb_pkg::item_t      item,
    input  logic                  slot_match,
    input  logic                  found,
    output msstb_pkg::slot_rec_t  rec_out,
    output msstb_pkg::head_stat_t stat
);
    import msstb_pkg::*;

    always_comb begin
        rec_out = rec_in;
        stat    = '0;
        case (item.command)
            CMD_TICK: begin
                if (!rec_in.free && rec_in.run) begin
                    if (rec_in.up) begin
                        if (rec_in.count < rec_in.limit) begin
                            rec_out.count = rec_in.count + CNT_W'(1);
                            stat.hit      = (rec_in.count + CNT_W'(1)) == rec_in.limit;
                        end
                    end else if (rec_in.count != '0) begin
                        rec_out.count = rec_in.count - CNT_W'(1);
                        stat.hit      = rec_in.count == CNT_W'(1);
                    end
                    if (stat.hit && rec_in.shot) begin
                        rec_out.free = 1'b1;
                        rec_out.run  = 1'b0;
                    end
                end
            end
            CMD_APPEND: begin
                // first free slot seen on the walk is the lowest one
                if (!found && rec_in.free) begin
                    rec_out.count = item.count_value;
                    rec_out.limit = item.limit_value;
                    rec_out.up    = item.count_up;
                    rec_out.shot  = item.one_shot;
                    rec_out.run   = item.active;
                    rec_out.free  = 1'b0;
                    stat.claim    = 1'b1;
                end
            end
            CMD_RELEASE: begin
                if (slot_match) begin
                    rec_out.free = 1'b1;
                    rec_out.run  = 1'b0;
                end
            end
            CMD_SET_ACTIVE: begin
                if (slot_match) begin
                    rec_out.run = item.active;
                end
            end
            CMD_SET_VALUE: begin
                if (slot_match) begin
                    if (rec_in.up) begin
                        rec_out.limit = item.count_value;
                        rec_out.count = '0;
                    end else begin
                        rec_out.count = item.count_value;
                    end
                    rec_out.run = item.active;
                end
            end
            default: begin
            end
        endcase
        stat.run_inc = !rec_in.run && rec_out.run;
        stat.run_dec = rec_in.run && !rec_out.run;
    end

endmodule

FILE: hdl/multi_slot_soft_timer_bank_unit.sv
// Top level: ring of timer slot cells walked once per command transaction.
// A result is registered at the end of a walk that moves every slot once past the head;
// the walk stalls on its last step while an earlier result waits. No new transaction is
// taken during a walk, as the single head unit serves every slot once per walk around the ring.
// The output register lets the next transaction enter while a result waits.
// Reset (aresetn low, synchronous): all slots free and idle at once, no clearing pass.
module multi_slot_soft_timer_bank_unit #(
    parameter int SLOTS = msstb_pkg::NUM_SLOTS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // command, slot, count_value, limit_value, count_up, one_shot, active; zero pad
    input  logic [msstb_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // slot_granted, no_free_slot, expired_mask, active_count; zero pad
    output logic [msstb_pkg::M_DATA_W-1:0]  m_tdata
);
    import msstb_pkg::*;

    `include "multi_slot_soft_timer_bank_unit_defines.svh"

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  step_reg, step_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic              m_tvalid_reg, m_tvalid_next;
    item_t             item_reg;
    logic              found_reg, found_next;
    logic [SLOT_W-1:0] granted_reg, granted_next;
    logic [CNT_W-1:0]  mask_reg, mask_next;
    result_t           out_reg, out_next;

    slot_rec_t  cell_q [SLOTS];
    slot_rec_t  head_rec;
    head_stat_t head_st;
    logic       shift_en;
    logic       last_step;
    logic       out_free;
    logic       slot_match;
    logic       in_fire;
    logic [SLOTS-1:0] run_vec;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign last_step = (step_reg == IDX_W'(SLOTS - 1));
    assign out_free  = !m_tvalid_reg || m_tready;
    assign shift_en  = (state_reg == ST_WALK) && (!last_step || out_free);
    assign slot_match = (SLOT_W'(step_reg) == item_reg.slot);

    // ring: each cell takes its upper neighbor, the top cell takes the head output
    for (genvar i = 0; i < SLOTS; i++) begin : g_ring
        if (i == SLOTS - 1) begin : g_top
            msstb_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .rec_in   (head_rec),
                .rec_out  (cell_q[i])
            );
        end else begin : g_mid
            msstb_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .rec_in   (cell_q[i+1]),
                .rec_out  (cell_q[i])
            );
        end
        assign run_vec[i] = cell_q[i].run;
    end

    msstb_head u_head (
        .rec_in     (cell_q[0]),
        .item       (item_reg),
        .slot_match (slot_match),
        .found      (found_reg),
        .rec_out    (head_rec),
        .stat       (head_st)
    );

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        total_next    = total_reg;
        found_next    = found_reg;
        granted_next  = granted_reg;
        mask_next     = mask_reg;
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next   = ST_WALK;
                    step_next    = '0;
                    found_next   = 1'b0;
                    granted_next = '0;
                    mask_next    = '0;
                end
            end
            ST_WALK: begin
                if (shift_en) begin
                    total_next = total_reg + TOTAL_W'(head_st.run_inc)
                               - TOTAL_W'(head_st.run_dec);
                    if (head_st.claim) begin
                        found_next   = 1'b1;
                        granted_next = SLOT_W'(step_reg);
                    end
                    if (head_st.hit) begin
                        mask_next = mask_reg | (CNT_W'(1) << step_reg);
                    end
                    if (last_step) begin
                        out_next.slot_granted = granted_next;
                        out_next.no_free_slot = (item_reg.command == CMD_APPEND) && !found_next;
                        out_next.expired_mask = mask_next;
                        out_next.active_count = total_next;
                        m_tvalid_next         = 1'b1;
                        state_next            = ST_IDLE;
                        step_next             = '0;
                    end else begin
                        step_next = step_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            total_reg    <= total_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            item_reg.command     <= s_tdata[2:0];
            item_reg.slot        <= s_tdata[7:3];
            item_reg.count_value <= s_tdata[39:8];
            item_reg.limit_value <= s_tdata[71:40];
            item_reg.count_up    <= s_tdata[72];
            item_reg.one_shot    <= s_tdata[73];
            item_reg.active      <= s_tdata[74];
        end
        found_reg   <= found_next;
        granted_reg <= granted_next;
        mask_reg    <= mask_next;
        out_reg     <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, out_reg.active_count, out_reg.expired_mask,
                       out_reg.no_free_slot, out_reg.slot_granted};

    `MSSTB_ASSERT_NOW(a_total_tracks_run, aclk, aresetn, 1'b1, total_reg == TOTAL_W'($countones(run_vec)), "active total out of step with run flags")
    `MSSTB_ASSERT_NOW(a_idle_step_zero, aclk, aresetn, state_reg == ST_IDLE, step_reg == '0, "walk counter not parked while idle")
    `MSSTB_ASSERT_NOW(a_nofree_clean, aclk, aresetn, m_tvalid_reg && out_reg.no_free_slot, out_reg.slot_granted == '0 && out_reg.expired_mask == '0, "failed append reports a slot or expiry")
    `MSSTB_ASSERT_NXT(a_stall_holds_walk, aclk, aresetn, state_reg == ST_WALK && !shift_en, $stable(step_reg) && $stable(total_reg), "ring moved while result stalled")

endmodule

FILE: sim/tb_multi_slot_soft_timer_bank_unit.sv
// Self-checking testbench for the timer slot bank: directed cases, bank fill, random traffic.
module tb_multi_slot_soft_timer_bank_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import msstb_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 485;
    localparam int DRAIN_CYCLES = 2 * NUM_SLOTS + 8;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    // Shadow copy of the slot bank
    logic [CNT_W-1:0]     tmr_count [NUM_SLOTS];
    logic [CNT_W-1:0]     tmr_limit [NUM_SLOTS];
    bit                   tmr_up [NUM_SLOTS];
    bit                   tmr_oneshot [NUM_SLOTS];
    bit                   tmr_run [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] free_slots;
    logic [TOTAL_W-1:0]   run_total;

    result_t expected_results[$];
    int      error_count;
    int      cycle_count;
    bit      no_idle;

    multi_slot_soft_timer_bank_unit #(
        .SLOTS(NUM_SLOTS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void clear_timer_bank();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            tmr_count[i]   = '0;
            tmr_limit[i]   = '0;
            tmr_up[i]      = 1'b0;
            tmr_oneshot[i] = 1'b0;
            tmr_run[i]     = 1'b0;
        end
        free_slots = '1;
        run_total  = '0;
    endfunction

    function automatic void set_run_flag(int s, bit on);
        if (tmr_run[s] && !on)
            run_total = run_total - TOTAL_W'(1);
        else if (!tmr_run[s] && on)
            run_total = run_total + TOTAL_W'(1);
        tmr_run[s] = on;
    endfunction

    function automatic result_t predict_timer_step(input logic [CMD_W-1:0] cmd,
                                                   input logic [SLOT_W-1:0] slot,
                                                   input logic [CNT_W-1:0] cval,
                                                   input logic [CNT_W-1:0] lval,
                                                   input bit up, input bit shot,
                                                   input bit act);
        result_t r;
        bit      hit;
        int      idx;
        r = '0;
        case (cmd)
            CMD_TICK: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    hit = 1'b0;
                    if (!free_slots[i] && tmr_run[i]) begin
                        if (tmr_up[i]) begin
                            if (tmr_count[i] < tmr_limit[i]) begin
                                tmr_count[i] = tmr_count[i] + 1;
                                hit = (tmr_count[i] == tmr_limit[i]);
                            end
                        end else if (tmr_count[i] != 0) begin
                            tmr_count[i] = tmr_count[i] - 1;
                            hit = (tmr_count[i] == 0);
                        end
                    end
                    if (hit) begin
                        r.expired_mask[i] = 1'b1;
                        if (tmr_oneshot[i]) begin
                            free_slots[i] = 1'b1;
                            set_run_flag(i, 1'b0);
                        end
                    end
                end
            end
            CMD_APPEND: begin
                if (free_slots == '0) begin
                    r.no_free_slot = 1'b1;
                end else begin
                    idx = 0;
                    while (!free_slots[idx])
                        idx++;
                    tmr_count[idx]   = cval;
                    tmr_limit[idx]   = lval;
                    tmr_up[idx]      = up;
                    tmr_oneshot[idx] = shot;
                    set_run_flag(idx, act);
                    free_slots[idx]  = 1'b0;
                    r.slot_granted   = idx[SLOT_W-1:0];
                end
            end
            CMD_RELEASE: begin
                if (slot < NUM_SLOTS) begin
                    free_slots[slot] = 1'b1;
                    set_run_flag(int'(slot), 1'b0);
                end
            end
            CMD_SET_ACTIVE: begin
                if (slot < NUM_SLOTS)
                    set_run_flag(int'(slot), act);
            end
            CMD_SET_VALUE: begin
                if (slot < NUM_SLOTS) begin
                    if (tmr_up[slot]) begin
                        tmr_limit[slot] = cval;
                        tmr_count[slot] = '0;
                    end else begin
                        tmr_count[slot] = cval;
                    end
                    set_run_flag(int'(slot), act);
                end
            end
            default: ;
        endcase
        r.active_count = run_total;
        return r;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int idle_len(int long_max);
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 16);
        return $urandom_range(17, long_max);
    endfunction

    function automatic logic [CNT_W-1:0] rand_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(0, 6);
        if (r < 85)
            return $urandom;
        if (r < 90)
            return '0;
        if (r < 95)
            return '1;
        return 32'hFFFF_FFFE;
    endfunction

    // Mostly an allocated slot, sometimes any slot
    function automatic logic [SLOT_W-1:0] pick_target();
        logic [SLOT_W-1:0] s;
        s = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
        if (free_slots != '1 && $urandom_range(0, 99) < 75) begin
            while (free_slots[s])
                s = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
        end
        return s;
    endfunction

    // Waits a random gap, maybe none, after the previous transaction; returns at the accepting edge.
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                            input logic [CNT_W-1:0] cval, input logic [CNT_W-1:0] lval,
                            input bit up, input bit shot, input bit act);
        int gap;
        gap = idle_len(80);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {5'b0, act, shot, up, lval, cval, slot, cmd};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(predict_timer_step(cmd, slot, cval, lval, up, shot, act));
    endtask

    task automatic tick();
        send_cmd(CMD_TICK, SLOT_W'($urandom), $urandom, $urandom,
                 1'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic hold_until_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_one_shot_expiry();
        tick();
        send_cmd(CMD_APPEND, '0, 32'd0, 32'd2, 1'b1, 1'b1, 1'b1);
        tick();
        tick();
    endtask

    task automatic test_periodic_expiry();
        send_cmd(CMD_APPEND, '1, 32'd2, '1, 1'b0, 1'b0, 1'b1);
        tick();
        tick();
        tick();   // down counter at zero holds
    endtask

    task automatic test_counters_at_end();
        send_cmd(CMD_APPEND, '0, '1, '1, 1'b1, 1'b0, 1'b1);
        send_cmd(CMD_APPEND, '0, '0, '0, 1'b0, 1'b1, 1'b1);
        tick();
    endtask

    task automatic test_set_value();
        send_cmd(CMD_SET_VALUE, 5'd1, 32'd1, '1, 1'b0, 1'b0, 1'b1);
        send_cmd(CMD_SET_VALUE, 5'd2, 32'd1, '0, 1'b1, 1'b1, 1'b1);
        tick();
    endtask

    task automatic test_set_active();
        send_cmd(CMD_SET_ACTIVE, 5'd1, '1, '1, 1'b1, 1'b1, 1'b0);
        send_cmd(CMD_SET_ACTIVE, 5'd0, '0, '0, 1'b0, 1'b0, 1'b0);
        tick();
    endtask

    // Commands aimed at free slots still write flags and values
    task automatic test_free_slot_writes();
        send_cmd(CMD_RELEASE, 5'd31, '0, '0, 1'b0, 1'b0, 1'b0);
        send_cmd(CMD_SET_ACTIVE, 5'd31, '0, '0, 1'b0, 1'b0, 1'b1);
        send_cmd(CMD_SET_VALUE, 5'd30, '1, '0, 1'b0, 1'b0, 1'b1);
        send_cmd(CMD_SET_ACTIVE, 5'd2, '0, '0, 1'b0, 1'b0, 1'b1);
        send_cmd(CMD_APPEND, '0, 32'd3, 32'd5, 1'b1, 1'b0, 1'b0);
        tick();
    endtask

    task automatic test_unknown_commands();
        for (int c = CMD_SET_VALUE + 1; c < (1 << CMD_W); c++)
            send_cmd(CMD_W'(c), '1, '1, '1, 1'b1, 1'b1, 1'b1);
    endtask

    task automatic test_bank_full();
        while (free_slots != '0)
            send_cmd(CMD_APPEND, '0, $urandom_range(0, 4), $urandom_range(0, 6),
                     1'($urandom), 1'($urandom), 1'($urandom));
        repeat (2)
            send_cmd(CMD_APPEND, '0, $urandom, $urandom,
                     1'($urandom), 1'($urandom), 1'($urandom));
        tick();
        repeat (8)
            send_cmd(CMD_RELEASE, SLOT_W'($urandom), $urandom, $urandom,
                     1'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic test_random_traffic(int n_items);
        int               r;
        bit               up;
        logic [CNT_W-1:0] cval;
        for (int n = 0; n < n_items; n++) begin
            no_idle = (n >= n_items / 4 && n < n_items / 4 + 60);
            if (n == n_items / 2)
                hold_until_drained();
            r = $urandom_range(0, 99);
            if (r < 40) begin
                tick();
            end else if (r < 60) begin
                up   = 1'($urandom);
                cval = up ? logic'($urandom_range(0, 99) < 80) ? $urandom_range(0, 2)
                                                                 : rand_count()
                          : rand_count();
                send_cmd(CMD_APPEND, SLOT_W'($urandom), cval, up ? rand_count() : $urandom,
                         up, 1'($urandom), $urandom_range(0, 99) < 85);
            end else if (r < 72) begin
                send_cmd(CMD_RELEASE, pick_target(), $urandom, $urandom,
                         1'($urandom), 1'($urandom), 1'($urandom));
            end else if (r < 82) begin
                send_cmd(CMD_SET_ACTIVE, pick_target(), $urandom, $urandom,
                         1'($urandom), 1'($urandom), 1'($urandom));
            end else if (r < 96) begin
                send_cmd(CMD_SET_VALUE, pick_target(), rand_count(), $urandom,
                         1'($urandom), 1'($urandom), $urandom_range(0, 99) < 80);
            end else begin
                send_cmd(CMD_W'($urandom_range(CMD_SET_VALUE + 1, (1 << CMD_W) - 1)),
                         SLOT_W'($urandom), $urandom, $urandom,
                         1'($urandom), 1'($urandom), 1'($urandom));
            end
        end
        no_idle = 1'b0;
    endtask

    // Result side back-pressure
    initial begin
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 99) < 30)
                    stall = idle_len(100);
            end
        end
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[$bits(result_t)-1:0]);
            if (expected_results.size() == 0) begin
                $display("%0t: result with none expected, actual %h", $time, m_tdata);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.slot_granted !== want.slot_granted) begin
                    $display("%0t: slot_granted expected %0d actual %0d",
                             $time, want.slot_granted, got.slot_granted);
                    error_count++;
                end
                if (got.no_free_slot !== want.no_free_slot) begin
                    $display("%0t: no_free_slot expected %0b actual %0b",
                             $time, want.no_free_slot, got.no_free_slot);
                    error_count++;
                end
                if (got.expired_mask !== want.expired_mask) begin
                    $display("%0t: expired_mask expected %h actual %h",
                             $time, want.expired_mask, got.expired_mask);
                    error_count++;
                end
                if (got.active_count !== want.active_count) begin
                    $display("%0t: active_count expected %0d actual %0d",
                             $time, want.active_count, got.active_count);
                    error_count++;
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        error_count = 0;
        no_idle     = 1'b0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        clear_timer_bank();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_one_shot_expiry();
        test_periodic_expiry();
        test_counters_at_end();
        test_set_value();
        test_set_active();
        test_free_slot_writes();
        test_unknown_commands();
        test_bank_full();
        test_random_traffic(RANDOM_ITEMS);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/msstb_pkg.sv
hdl/msstb_cell.sv
hdl/msstb_head.sv
hdl/multi_slot_soft_timer_bank_unit.sv
sim/tb_multi_slot_soft_timer_bank_unit.sv
